// ----- src/round_robin_task_scheduler_macros.svh -----
// Assertion macros for the round-robin task scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define RRTS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRTS_ASSERT(lbl, clk, rstn, prop, msg)
`define RRTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/rrts_pkg.sv -----
// Types and constants shared by the task scheduler modules.
`default_nettype none
package rrts_pkg;
	localparam int TASK_SLOTS = 128;
	localparam int TIME_BITS  = 32;
	localparam int IDX_W      = $clog2(TASK_SLOTS);
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int KEY_W      = 9;

	typedef enum logic [2:0] {
		TS_RUN    = 3'd0,
		TS_SLEEP  = 3'd1,
		TS_INPUT  = 3'd2,
		TS_READY  = 3'd3,
		TS_FINISH = 3'd4
	} task_st_t;

	typedef enum logic [2:0] {
		RQ_CREATE = 3'd0,
		RQ_EXIT   = 3'd1,
		RQ_SLEEP  = 3'd2,
		RQ_WAIT   = 3'd3,
		RQ_READ   = 3'd4,
		RQ_POLL   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_BAD   = 2'd2,
		STS_NORUN = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REQ,
		S_CUR,
		S_TGT,
		S_SC_RD,
		S_SC_EV,
		S_SC_JN,
		S_FIN
	} fsm_t;

	typedef struct packed {
		task_st_t             st;
		logic [TIME_BITS-1:0] wake;
		logic                 join_on;
		logic [IDX_W-1:0]     join_tg;
		logic                 key_on;
		logic [KEY_W-1:0]     key;
	} tword_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		tword_t           wdata;
		logic [IDX_W-1:0] raddr;
	} tbl_req_t;

	localparam tword_t TWORD_RESET = '{st: TS_RUN, wake: '0, join_on: 1'b0,
		join_tg: '0, key_on: 1'b0, key: '0};
endpackage
`default_nettype wire

// ----- src/rrts_task_table.sv -----
// Task table memory: one word per task, one write and one registered read a cycle.
`default_nettype none
module rrts_task_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rrts_pkg::tbl_req_t req,
	output rrts_pkg::tword_t       rdata
);
	import rrts_pkg::*;

	tword_t mem [TASK_SLOTS];
	tword_t rd_q;
	logic   fresh_q;
	logic   rd0_q;

	// entry 0 reads as its reset value until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b1;
			rd0_q   <= 1'b1;
		end else begin
			rd0_q <= fresh_q && (req.raddr == '0);
			if (req.we && (req.waddr == '0)) begin
				fresh_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	assign rdata = rd0_q ? TWORD_RESET : rd_q;
endmodule
`default_nettype wire

// ----- src/round_robin_task_scheduler.sv -----
// Top level of the round-robin task scheduler: sequencer and slot evaluator.
//
//  channel | handshake          | payload
//  request | start, busy        | req_type now_ms sleep_ms target_task key_valid key_code
//  result  | done (one cycle)   | run_task run_valid new_handle key_taken key_delivered
//          |                    | delivered_key status
//
// A request that needs no selection goes from the request step to the finish step;
// an update of the running task adds a step (and a target step for a wait), and a
// selection adds a read and an evaluate step for every task slot it visits (and a
// join step when the slot is joined). The task table reads one slot word per step.
// busy is high from acceptance until the cycle of done; done lasts one cycle
// and the receiver cannot stall it. Reset brings up task 0 running, one task.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"
module round_robin_task_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [2:0]                    req_type,
	input  wire logic [31:0]                   now_ms,
	input  wire logic [31:0]                   sleep_ms,
	input  wire logic [rrts_pkg::IDX_W-1:0]    target_task,
	input  wire logic                          key_valid,
	input  wire logic [rrts_pkg::KEY_W-1:0]    key_code,
	output logic                               done,
	output logic [rrts_pkg::IDX_W-1:0]         run_task,
	output logic                               run_valid,
	output logic [rrts_pkg::IDX_W-1:0]         new_handle,
	output logic                               key_taken,
	output logic                               key_delivered,
	output logic [rrts_pkg::KEY_W-1:0]         delivered_key,
	output logic [1:0]                         status
);
	import rrts_pkg::*;

	fsm_t                 state_q, state_d;
	req_t                 req_q;
	logic [TIME_BITS-1:0] now_q, slp_q;
	logic [IDX_W-1:0]     tgt_q;
	logic                 kv_q;
	logic [KEY_W-1:0]     kc_q;
	logic [IDX_W-1:0]     run_task_q;
	logic                 run_flag_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     cur_q, iter_q;
	logic                 taken_q, deliver_q;
	logic [KEY_W-1:0]     dkey_q;
	status_t              status_q;
	logic [IDX_W-1:0]     newh_q;
	tword_t               hold_q;
	logic                 done_q;
	logic [IDX_W-1:0]     out_task_q, out_newh_q;
	logic                 out_valid_q, out_taken_q, out_deliver_q;
	logic [KEY_W-1:0]     out_dkey_q;
	status_t              out_status_q;

	tbl_req_t tbl;
	tword_t   rword;

	rrts_task_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl),
		.rdata  (rword)
	);

	// ---- datapath decisions ----
	logic             accept;
	logic             create_ok, tgt_ok, need_cur, poll_scan;
	tword_t           new_word, cur_word, wait_word, ev_word, sel_src, sel_word;
	logic             ev_take, ev_ready, ev_join, tgt_fin, jn_fin;
	logic             scan_last;
	logic [CNT_W-1:0] cur_inc, cur_next, run_inc, scan_first;

	assign accept    = start && !busy;
	assign create_ok = count_q != CNT_W'(TASK_SLOTS);
	assign tgt_ok    = {1'b0, tgt_q} < count_q;
	assign need_cur  = run_flag_q && ((req_q == RQ_EXIT) || (req_q == RQ_SLEEP)
		|| (req_q == RQ_READ) || ((req_q == RQ_WAIT) && tgt_ok));
	assign poll_scan = (req_q == RQ_POLL) && !run_flag_q;

	assign cur_inc    = cur_q + 1'b1;
	assign cur_next   = (cur_inc == count_q) ? '0 : cur_inc;
	assign run_inc    = {1'b0, run_task_q} + 1'b1;
	assign scan_first = (run_inc == count_q) ? '0 : run_inc;
	assign scan_last  = (iter_q + 1'b1) == count_q;

	always_comb begin
		new_word    = '0;
		new_word.st = TS_READY;

		// update the running task's word for its own request
		cur_word = rword;
		case (req_q)
			RQ_EXIT:  cur_word.st = TS_FINISH;
			RQ_SLEEP: begin
				cur_word.st   = TS_SLEEP;
				cur_word.wake = now_q + slp_q;
			end
			RQ_READ: begin
				if (rword.key_on) begin
					cur_word.key_on = 1'b0;
					cur_word.key    = '0;
				end else begin
					cur_word.st = TS_INPUT;
				end
			end
			default: cur_word = rword;
		endcase

		tgt_fin           = rword.st == TS_FINISH;
		wait_word         = hold_q;
		wait_word.st      = TS_READY;
		wait_word.join_on = 1'b1;
		wait_word.join_tg = tgt_q;

		// shared slot evaluator: wake, hand over key, test readiness
		ev_word = rword;
		ev_take = 1'b0;
		if ((ev_word.st == TS_SLEEP) && (now_q >= ev_word.wake)) begin
			ev_word.st = TS_READY;
		end
		if ((ev_word.st == TS_INPUT) && kv_q && !taken_q) begin
			ev_word.st     = TS_READY;
			ev_word.key_on = 1'b1;
			ev_word.key    = kc_q;
			ev_take        = 1'b1;
		end
		ev_ready = ev_word.st == TS_READY;
		ev_join  = ev_ready && ev_word.join_on;

		// a slot joined on itself sees its own READY state, never finished
		jn_fin = (hold_q.join_tg == cur_q[IDX_W-1:0]) ? (hold_q.st == TS_FINISH)
			: (rword.st == TS_FINISH);

		sel_src = ev_word;
		if (state_q == S_SC_JN) begin
			sel_src         = hold_q;
			sel_src.join_on = 1'b0;
			sel_src.join_tg = '0;
		end
		sel_word        = sel_src;
		sel_word.st     = TS_RUN;
		sel_word.key_on = 1'b0;
		sel_word.key    = '0;
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_REQ;
			S_REQ: begin
				if (need_cur)       state_d = S_CUR;
				else if (poll_scan) state_d = S_SC_RD;
				else                state_d = S_FIN;
			end
			S_CUR: begin
				if (req_q == RQ_WAIT)                     state_d = S_TGT;
				else if ((req_q == RQ_READ) && rword.key_on) state_d = S_FIN;
				else                                      state_d = S_SC_RD;
			end
			S_TGT:   state_d = tgt_fin ? S_FIN : S_SC_RD;
			S_SC_RD: state_d = S_SC_EV;
			S_SC_EV: begin
				if (ev_join)                      state_d = S_SC_JN;
				else if (ev_ready || scan_last)   state_d = S_FIN;
				else                              state_d = S_SC_RD;
			end
			S_SC_JN: state_d = (jn_fin || scan_last) ? S_FIN : S_SC_RD;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---- table access per state ----
	always_comb begin
		tbl       = '0;
		tbl.raddr = cur_q[IDX_W-1:0];
		case (state_q)
			S_REQ: begin
				tbl.raddr = run_task_q;
				if ((req_q == RQ_CREATE) && create_ok) begin
					tbl.we    = 1'b1;
					tbl.waddr = count_q[IDX_W-1:0];
					tbl.wdata = new_word;
				end
			end
			S_CUR: begin
				tbl.raddr = tgt_q;
				if (req_q != RQ_WAIT) begin
					tbl.we    = 1'b1;
					tbl.waddr = run_task_q;
					tbl.wdata = cur_word;
				end
			end
			S_TGT: begin
				tbl.we    = !tgt_fin;
				tbl.waddr = run_task_q;
				tbl.wdata = wait_word;
			end
			S_SC_EV: begin
				if (ev_join) begin
					tbl.raddr = ev_word.join_tg;
				end else begin
					tbl.we    = 1'b1;
					tbl.waddr = cur_q[IDX_W-1:0];
					tbl.wdata = ev_ready ? sel_word : ev_word;
				end
			end
			S_SC_JN: begin
				tbl.we    = 1'b1;
				tbl.waddr = cur_q[IDX_W-1:0];
				tbl.wdata = jn_fin ? sel_word : hold_q;
			end
			default: tbl.we = 1'b0;
		endcase
	end

	// ---- control and per-request registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			run_task_q <= '0;
			run_flag_q <= 1'b1;
			count_q    <= CNT_W'(1);
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == S_FIN;
			case (state_q)
				S_REQ: begin
					if ((req_q == RQ_CREATE) && create_ok) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_SC_EV: begin
					if (ev_ready && !ev_join) begin
						run_task_q <= cur_q[IDX_W-1:0];
						run_flag_q <= 1'b1;
					end else if (!ev_join && scan_last) begin
						run_flag_q <= 1'b0;
					end
				end
				S_SC_JN: begin
					if (jn_fin) begin
						run_task_q <= cur_q[IDX_W-1:0];
						run_flag_q <= 1'b1;
					end else if (scan_last) begin
						run_flag_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// hold the request and the running answer fields
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_t'(req_type);
			now_q     <= TIME_BITS'(now_ms);
			slp_q     <= TIME_BITS'(sleep_ms);
			tgt_q     <= target_task;
			kv_q      <= key_valid;
			kc_q      <= key_code;
			taken_q   <= 1'b0;
			deliver_q <= 1'b0;
			dkey_q    <= '0;
			status_q  <= STS_OK;
			newh_q    <= '0;
		end
		case (state_q)
			S_REQ: begin
				cur_q  <= scan_first;
				iter_q <= '0;
				if (req_q == RQ_CREATE) begin
					if (create_ok) newh_q <= count_q[IDX_W-1:0];
					else           status_q <= STS_FULL;
				end else if (!run_flag_q && (req_q == RQ_EXIT || req_q == RQ_SLEEP
						|| req_q == RQ_WAIT || req_q == RQ_READ)) begin
					status_q <= STS_NORUN;
				end else if ((req_q == RQ_WAIT) && !tgt_ok) begin
					status_q <= STS_BAD;
				end
			end
			S_CUR: begin
				hold_q <= rword;
				if ((req_q == RQ_READ) && rword.key_on) begin
					deliver_q <= 1'b1;
					dkey_q    <= rword.key;
				end
			end
			S_SC_EV: begin
				hold_q <= ev_word;
				if (ev_take) taken_q <= 1'b1;
				if (ev_ready && !ev_join && ev_word.key_on) begin
					deliver_q <= 1'b1;
					dkey_q    <= ev_word.key;
				end
				if (!ev_ready) begin
					cur_q  <= cur_next;
					iter_q <= iter_q + 1'b1;
				end
			end
			S_SC_JN: begin
				if (jn_fin && hold_q.key_on) begin
					deliver_q <= 1'b1;
					dkey_q    <= hold_q.key;
				end
				cur_q  <= cur_next;
				iter_q <= iter_q + 1'b1;
			end
			S_FIN: begin
				out_task_q    <= run_flag_q ? run_task_q : '0;
				out_valid_q   <= run_flag_q;
				out_newh_q    <= newh_q;
				out_taken_q   <= taken_q;
				out_deliver_q <= deliver_q;
				out_dkey_q    <= dkey_q;
				out_status_q  <= status_q;
			end
			default: ;
		endcase
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign run_task      = out_task_q;
	assign run_valid     = out_valid_q;
	assign new_handle    = out_newh_q;
	assign key_taken     = out_taken_q;
	assign key_delivered = out_deliver_q;
	assign delivered_key = out_dkey_q;
	assign status        = out_status_q;

	// a result appears only once the sequencer is back at rest
	`RRTS_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while busy")
	// an accepted request always occupies the sequencer next cycle
	`RRTS_ASSERT(a_accept_busy, clk, arst_n, accept |=> busy, "request not taken up")
	// an idle answer carries no task handle
	`RRTS_ASSERT(a_idle_zero, clk, arst_n, (done && !run_valid) |-> (run_task == '0),
		"idle result names a task")
	// a rejected request never consumes the offered key
	`RRTS_ASSERT(a_err_nokey, clk, arst_n, (done && (status != STS_OK)) |-> !key_taken,
		"key taken on rejected request")
	// task count stays within the table
	`RRTS_ASSERT(a_count_rng, clk, arst_n, (count_q != '0) && (count_q <= CNT_W'(TASK_SLOTS)),
		"task count out of range")
endmodule
`default_nettype wire
